// File: design/kltab_pkg.sv
`timescale 1ns / 1ps

package kltab_pkg;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_FIRST  = 3'd3,
    ACT_NEXT   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_FULL = 3'd1,
    ST_DUP  = 3'd2,
    ST_MISS = 3'd3,
    ST_END  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_FETCH
  } state_t;

  typedef enum logic [1:0] {
    DM_IDLE,
    DM_LOAD,
    DM_SCAN,
    DM_SHIFT
  } dp_mode_t;

  typedef enum logic [2:0] {
    W_HOLD,
    W_CLEAR,
    W_FIRST,
    W_NEXT,
    W_HIT
  } walk_op_t;

  typedef enum logic [1:0] {
    FS_ZERO,
    FS_READ,
    FS_INPUT
  } found_sel_t;

  typedef struct packed {
    dp_mode_t   mode;
    logic       rd_zero;
    logic       rd_walk;
    walk_op_t   walk;
    logic       append;
    logic       dec_count;
    logic       finish;
    status_t    status;
    found_sel_t found;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    empty;
    logic    walk_valid;
    logic    walk_last;
    logic    hit;
    logic    miss;
    logic    shift_done;
  } dp_stat_t;

endpackage

// File: design/kltab_ctrl.sv
`timescale 1ns / 1ps

module kltab_ctrl
  import kltab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.action)
          ACT_ADD:    state_next = stat.full ? S_IDLE : S_SCAN;
          ACT_LOOKUP: state_next = S_SCAN;
          ACT_DELETE: state_next = stat.empty ? S_IDLE : S_SCAN;
          ACT_FIRST:  state_next = stat.empty ? S_IDLE : S_FETCH;
          ACT_NEXT: begin
            state_next = (!stat.walk_valid || stat.walk_last) ? S_IDLE : S_FETCH;
          end
          default:    state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = (stat.action == ACT_DELETE) ? S_SHIFT : S_IDLE;
        end else if (stat.miss) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) state_next = S_IDLE;
      end
      S_FETCH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{mode: DM_IDLE, rd_zero: 1'b0, rd_walk: 1'b0, walk: W_HOLD, append: 1'b0,
            dec_count: 1'b0, finish: 1'b0, status: ST_OK, found: FS_ZERO};
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) cmd.mode = DM_LOAD;
      end
      S_DECODE: begin
        case (stat.action)
          ACT_ADD: begin
            if (stat.full) begin
              cmd.finish = 1'b1;
              cmd.status = ST_FULL;
            end
          end
          ACT_LOOKUP: begin
          end
          ACT_DELETE: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.status = ST_END;
            end
          end
          ACT_FIRST: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.status = ST_END;
              cmd.walk   = W_CLEAR;
            end else begin
              cmd.rd_zero = 1'b1;
              cmd.walk    = W_FIRST;
            end
          end
          ACT_NEXT: begin
            if (!stat.walk_valid || stat.walk_last) begin
              cmd.finish = 1'b1;
              cmd.status = ST_END;
              cmd.walk   = W_CLEAR;
            end else begin
              cmd.rd_walk = 1'b1;
              cmd.walk    = W_NEXT;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        cmd.mode = DM_SCAN;
        if (stat.hit) begin
          cmd.finish = 1'b1;
          cmd.found  = FS_READ;
          case (stat.action)
            ACT_ADD: begin
              cmd.status = ST_DUP;
              cmd.walk   = W_HIT;
            end
            ACT_DELETE: begin
              cmd.walk      = W_CLEAR;
              cmd.dec_count = 1'b1;
            end
            default: begin
              cmd.walk = W_HIT;
            end
          endcase
        end else if (stat.miss) begin
          cmd.finish = 1'b1;
          cmd.walk   = W_CLEAR;
          if (stat.action == ACT_ADD) begin
            cmd.append = 1'b1;
            cmd.found  = FS_INPUT;
          end else begin
            cmd.status = ST_MISS;
          end
        end
      end
      S_SHIFT: begin
        cmd.mode = DM_SHIFT;
      end
      S_FETCH: begin
        cmd.finish = 1'b1;
        cmd.found  = FS_READ;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/kltab_dpath.sv
`timescale 1ns / 1ps

module kltab_dpath
  import kltab_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         action,
  input  logic signed [31:0] key,
  input  logic [31:0]        payload,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] found_key,
  output logic [31:0]        found_payload,
  output logic [6:0]         occupancy
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [31:0] mem_key [TABLE_DEPTH];
  logic [31:0] mem_pay [TABLE_DEPTH];

  action_t     action_q;
  logic [31:0] key_q;
  logic [31:0] payload_q;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_addr;
  logic [AW-1:0] rd_addr_q;
  logic          rd_valid;
  logic [31:0]   rkey;
  logic [31:0]   rpay;
  logic [AW-1:0] walk_pos;
  logic          walk_valid;

  logic          rd_en;
  logic [AW-1:0] rd_addr_next;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_key;
  logic [31:0]   wr_pay;
  logic          hit;
  logic [CW:0]   walk_succ;
  logic [CW+6:0] occ_ext;

  assign hit = (cmd.mode == DM_SCAN) && rd_valid && (rkey == key_q);
  assign walk_succ = (CW+1)'(walk_pos) + (CW+1)'(1);

  always_comb begin
    rd_en = 1'b0;
    case (cmd.mode)
      DM_SCAN:  rd_en = !hit && (scan_addr < count);
      DM_SHIFT: rd_en = (scan_addr <= count);
      default:  rd_en = cmd.rd_zero || cmd.rd_walk;
    endcase
  end

  always_comb begin
    if (cmd.rd_zero) begin
      rd_addr_next = '0;
    end else if (cmd.rd_walk) begin
      rd_addr_next = walk_succ[AW-1:0];
    end else begin
      rd_addr_next = scan_addr[AW-1:0];
    end
  end

  // Shift copies the word just read one place down; append writes at the count.
  assign wr_en   = cmd.append || ((cmd.mode == DM_SHIFT) && rd_valid);
  assign wr_addr = cmd.append ? count[AW-1:0] : rd_addr_q - AW'(1);
  assign wr_key  = cmd.append ? key_q : rkey;
  assign wr_pay  = cmd.append ? payload_q : rpay;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_pay[wr_addr] <= wr_pay;
    end
    if (rd_en) begin
      rkey <= mem_key[rd_addr_next];
      rpay <= mem_pay[rd_addr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mode == DM_LOAD) begin
      action_q  <= action_t'(action);
      key_q     <= key;
      payload_q <= payload;
    end
    if (rd_en) rd_addr_q <= rd_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      scan_addr  <= '0;
      rd_valid   <= 1'b0;
      walk_pos   <= '0;
      walk_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cmd.mode == DM_LOAD) begin
        scan_addr <= '0;
      end else if (rd_en && (cmd.mode == DM_SCAN || cmd.mode == DM_SHIFT)) begin
        scan_addr <= scan_addr + CW'(1);
      end
      rd_valid <= rd_en && (cmd.mode == DM_SCAN || cmd.mode == DM_SHIFT);

      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.dec_count) begin
        count <= count - CW'(1);
      end

      case (cmd.walk)
        W_CLEAR: begin
          walk_pos   <= '0;
          walk_valid <= 1'b0;
        end
        W_FIRST: begin
          walk_pos   <= '0;
          walk_valid <= 1'b1;
        end
        W_NEXT: begin
          walk_pos <= walk_succ[AW-1:0];
        end
        W_HIT: begin
          walk_pos   <= rd_addr_q;
          walk_valid <= 1'b1;
        end
        default: begin
        end
      endcase

      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= cmd.status;
      case (cmd.found)
        FS_READ: begin
          found_key     <= rkey;
          found_payload <= rpay;
        end
        FS_INPUT: begin
          found_key     <= key_q;
          found_payload <= payload_q;
        end
        default: begin
          found_key     <= '0;
          found_payload <= '0;
        end
      endcase
    end
  end

  assign occ_ext   = {7'd0, count};
  assign occupancy = occ_ext[6:0];

  always_comb begin
    stat.action     = action_q;
    stat.full       = (count == DEPTH_C);
    stat.empty      = (count == '0);
    stat.walk_valid = walk_valid;
    stat.walk_last  = (walk_succ >= (CW+1)'(count));
    stat.hit        = hit;
    stat.miss       = (cmd.mode == DM_SCAN) && !rd_valid && (scan_addr >= count);
    stat.shift_done = (cmd.mode == DM_SHIFT) && !rd_valid && (scan_addr > count);
  end

endmodule

// File: design/keyed_list_table_core.sv
`timescale 1ns / 1ps

// Keyed list table: up to TABLE_DEPTH entries of a signed 32-bit key and a
// 32-bit payload handle, kept in insertion order with unique keys. Pulse start
// with a word (action, key, payload) while busy is low; exactly one result word
// comes back later on status/found_key/found_payload/occupancy, marked by done
// for a single cycle. The receiver cannot stall: capture the result in the
// cycle that done is high. Add, lookup and delete search a single-port-read
// key/payload memory swept one entry per cycle, up to the match or the count.
// First and next read the entry in decode and return it from the fetch state.
// Delete returns its result after the search, then holds busy while the
// later entries move down one place. Add on a full table, delete on an empty
// one, first on an empty table, next with no cursor or at the last entry,
// and unused action codes finish straight from decode. Apart from delete, a
// new word can be taken at the edge that takes the result. No clearing pass
// follows reset: the table starts empty and only held entries are ever read.
module keyed_list_table_core
  import kltab_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic signed [31:0] key,
  input  logic [31:0]        payload,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] found_key,
  output logic [31:0]        found_payload,
  output logic [6:0]         occupancy
);

  // Command and status between sequencer and table datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Decode the action, drive the scan, shift and walk steps.
  kltab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Hold the entry memories, count, cursor and the registered result word.
  kltab_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .key           (key),
    .payload       (payload),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .found_key     (found_key),
    .found_payload (found_payload),
    .occupancy     (occupancy)
  );

endmodule
